@@ hw/rtl/usrd_pkg.sv @@
`timescale 1ns / 1ps
// shared types, request codes and helpers of the usb standard request decoder
package usrd_pkg;

   typedef enum logic [1:0] {
      ACT_ACK     = 2'd0,
      ACT_SEND    = 2'd1,
      ACT_STALL   = 2'd2,
      ACT_WRITTEN = 2'd3
   } action_type;

   localparam logic OP_SETUP      = 1'b0;
   localparam logic OP_WRITE_SLOT = 1'b1;

   // request word is {bRequest, bmRequestType}
   localparam logic [15:0] REQ_SET_LINE_CODING   = 16'h2021;
   localparam logic [15:0] REQ_SET_CTRL_LINE     = 16'h2221;
   localparam logic [15:0] REQ_SET_ADDRESS       = 16'h0500;
   localparam logic [15:0] REQ_SET_INTERFACE     = 16'h0b01;
   localparam logic [15:0] REQ_SET_CONFIG        = 16'h0900;
   localparam logic [15:0] REQ_GET_CONFIG        = 16'h0880;
   localparam logic [15:0] REQ_GET_STATUS_DEV    = 16'h0080;
   localparam logic [15:0] REQ_GET_STATUS_EP     = 16'h0082;
   localparam logic [15:0] REQ_CLEAR_FEATURE_EP  = 16'h0102;
   localparam logic [15:0] REQ_SET_FEATURE_EP    = 16'h0302;
   localparam logic [15:0] REQ_GET_DESC_DEV      = 16'h0680;
   localparam logic [15:0] REQ_GET_DESC_IF       = 16'h0681;

   localparam logic [7:0]  DESC_TYPE_STRING      = 8'h03;
   localparam logic [15:0] CONFIG_REPLY_LENGTH   = 16'd1;
   localparam logic [15:0] STATUS_REPLY_LENGTH   = 16'd2;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic [15:0] key;
      logic [15:0] length;
      logic [7:0]  first_byte;
   } entry_type;

   typedef struct packed {
      action_type  action;
      logic        from_descriptor;
      logic [3:0]  matched_slot;
      logic [15:0] send_length;
      logic [7:0]  reply_first;
      logic        address_update;
      logic [7:0]  new_address;
   } result_type;

   typedef struct packed {
      result_type result;
      logic       is_descriptor;
      logic       config_write;
   } decode_type;

   function automatic logic [15:0] clamp_length(input logic [15:0] len,
                                                input logic [15:0] limit);
      clamp_length = (len > limit) ? limit : len;
   endfunction

endpackage

@@ hw/rtl/usrd_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
module usrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/usrd_decode.sv @@
`timescale 1ns / 1ps
// setup packet decode for every request that needs no table lookup; descriptor requests are only flagged
module usrd_decode (
   input  logic [7:0]          request_type,
   input  logic [7:0]          request_code,
   input  logic [15:0]         value,
   input  logic [15:0]         target_index,
   input  logic [15:0]         requested_length,
   input  logic [7:0]          active_configuration,
   output usrd_pkg::decode_type dec
);

   logic [15:0] word;

   assign word = {request_code, request_type};

   always_comb begin
      dec = '0;
      dec.result.action = usrd_pkg::ACT_STALL;
      case (word)
         usrd_pkg::REQ_SET_LINE_CODING,
         usrd_pkg::REQ_SET_CTRL_LINE,
         usrd_pkg::REQ_SET_INTERFACE: begin
            dec.result.action = usrd_pkg::ACT_ACK;
         end
         usrd_pkg::REQ_SET_ADDRESS: begin
            dec.result.action = usrd_pkg::ACT_ACK;
            dec.result.address_update = 1'b1;
            dec.result.new_address = value[7:0];
         end
         usrd_pkg::REQ_SET_CONFIG: begin
            dec.result.action = usrd_pkg::ACT_ACK;
            dec.config_write = 1'b1;
         end
         usrd_pkg::REQ_GET_CONFIG: begin
            dec.result.action = usrd_pkg::ACT_SEND;
            dec.result.reply_first = active_configuration;
            dec.result.send_length = usrd_pkg::clamp_length(
               usrd_pkg::CONFIG_REPLY_LENGTH, requested_length);
         end
         usrd_pkg::REQ_GET_STATUS_DEV: begin
            dec.result.action = usrd_pkg::ACT_SEND;
            dec.result.send_length = usrd_pkg::clamp_length(
               usrd_pkg::STATUS_REPLY_LENGTH, requested_length);
         end
         usrd_pkg::REQ_GET_STATUS_EP: begin
            if (target_index == 16'd0) begin
               dec.result.action = usrd_pkg::ACT_SEND;
               dec.result.send_length = usrd_pkg::clamp_length(
                  usrd_pkg::STATUS_REPLY_LENGTH, requested_length);
            end
         end
         usrd_pkg::REQ_CLEAR_FEATURE_EP,
         usrd_pkg::REQ_SET_FEATURE_EP: begin
            if (target_index == 16'd0 && value == 16'd0) begin
               dec.result.action = usrd_pkg::ACT_ACK;
            end
         end
         usrd_pkg::REQ_GET_DESC_DEV,
         usrd_pkg::REQ_GET_DESC_IF: begin
            dec.is_descriptor = 1'b1;
         end
         default: begin
            dec.result.action = usrd_pkg::ACT_STALL;
         end
      endcase
   end

endmodule

@@ hw/rtl/usb_standard_request_decoder_unit.sv @@
`timescale 1ns / 1ps
// top level: descriptor table, request sequencing and result registers
// table writes and plain requests give their result in the cycle after accept,
//   and busy stays low, so one such transaction can be taken every cycle
// get descriptor scans the table ram one slot per cycle, with busy high for all but
//   the result cycle; the scan ends at the first empty or matching slot or the last one
// synchronous reset clears the slot present bits and the active configuration;
//   the table ram itself is not cleared, results are never stalled
module usb_standard_request_decoder_unit #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [7:0]  req_request_type,
   input  logic [7:0]  req_request_code,
   input  logic [15:0] req_value,
   input  logic [15:0] req_target_index,
   input  logic [15:0] req_requested_length,
   input  logic [3:0]  req_slot,
   input  logic        req_slot_valid,
   input  logic [15:0] req_slot_key,
   input  logic [15:0] req_slot_length,
   input  logic [7:0]  req_slot_first_byte,
   output logic        rsp_valid,
   output logic [1:0]  rsp_action,
   output logic        rsp_from_descriptor,
   output logic [3:0]  rsp_matched_slot,
   output logic [15:0] rsp_send_length,
   output logic [7:0]  rsp_reply_first,
   output logic [7:0]  rsp_reply_second,
   output logic        rsp_address_update,
   output logic [7:0]  rsp_new_address
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ENTRY_W = $bits(usrd_pkg::entry_type);

   usrd_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]     chk_ff, chk_in;
   logic [15:0]          value_ff, value_in;
   logic [15:0]          rlen_ff, rlen_in;
   logic [7:0]           config_ff, config_in;
   logic [TABLE_ENTRIES-1:0] present_ff, present_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   usrd_pkg::result_type rsp_ff, rsp_in;

   logic                 accept;
   logic                 slot_write;
   logic [IDX_W-1:0]     wr_addr;
   logic [IDX_W-1:0]     rd_addr;
   usrd_pkg::entry_type  wr_entry;
   usrd_pkg::entry_type  rd_entry;
   logic [ENTRY_W-1:0]   rd_bits;
   usrd_pkg::decode_type dec;
   logic [15:0]          desc_len;

   assign accept = start && !busy;
   assign busy = (state_ff != usrd_pkg::ST_IDLE);
   assign slot_write = accept && (req_opcode == usrd_pkg::OP_WRITE_SLOT) &&
                       (32'(req_slot) < TABLE_ENTRIES);
   assign wr_addr = IDX_W'(req_slot);
   assign wr_entry = '{key: req_slot_key, length: req_slot_length,
                       first_byte: req_slot_first_byte};
   // next slot is fetched while the current one is compared
   assign rd_addr = (state_ff == usrd_pkg::ST_SCAN) ? chk_ff + IDX_W'(1) : '0;
   assign rd_entry = usrd_pkg::entry_type'(rd_bits);

   usrd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (slot_write),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   usrd_decode u_decode (
      .request_type         (req_request_type),
      .request_code         (req_request_code),
      .value                (req_value),
      .target_index         (req_target_index),
      .requested_length     (req_requested_length),
      .active_configuration (config_ff),
      .dec                  (dec)
   );

   // string descriptors report their first byte as length
   assign desc_len = (value_ff[15:8] == usrd_pkg::DESC_TYPE_STRING) ?
                     16'(rd_entry.first_byte) : rd_entry.length;

   always_comb begin
      state_in = state_ff;
      chk_in = chk_ff;
      value_in = value_ff;
      rlen_in = rlen_ff;
      config_in = config_ff;
      present_in = present_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         usrd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == usrd_pkg::OP_WRITE_SLOT) begin
                  if (slot_write) begin
                     present_in[wr_addr] = req_slot_valid;
                  end
                  rsp_in = '0;
                  rsp_in.action = usrd_pkg::ACT_WRITTEN;
                  rsp_valid_in = 1'b1;
               end else if (dec.is_descriptor) begin
                  value_in = req_value;
                  rlen_in = req_requested_length;
                  chk_in = '0;
                  state_in = usrd_pkg::ST_SCAN;
               end else begin
                  if (dec.config_write) begin
                     config_in = req_value[7:0];
                  end
                  rsp_in = dec.result;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         usrd_pkg::ST_SCAN: begin
            rsp_in = '0;
            rsp_in.action = usrd_pkg::ACT_STALL;
            if (!present_ff[chk_ff]) begin
               rsp_valid_in = 1'b1;
               state_in = usrd_pkg::ST_IDLE;
            end else if (rd_entry.key == value_ff) begin
               if (desc_len != 16'd0) begin
                  rsp_in.action = usrd_pkg::ACT_SEND;
                  rsp_in.from_descriptor = 1'b1;
                  rsp_in.matched_slot = 4'(chk_ff);
                  rsp_in.send_length = usrd_pkg::clamp_length(desc_len, rlen_ff);
               end else begin
                  rsp_in.action = usrd_pkg::ACT_ACK;
               end
               rsp_valid_in = 1'b1;
               state_in = usrd_pkg::ST_IDLE;
            end else if (chk_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               rsp_valid_in = 1'b1;
               state_in = usrd_pkg::ST_IDLE;
            end else begin
               chk_in = chk_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = usrd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= usrd_pkg::ST_IDLE;
         config_ff <= '0;
         present_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         config_ff <= config_in;
         present_ff <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff <= chk_in;
      value_ff <= value_in;
      rlen_ff <= rlen_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_action = rsp_ff.action;
   assign rsp_from_descriptor = rsp_ff.from_descriptor;
   assign rsp_matched_slot = rsp_ff.matched_slot;
   assign rsp_send_length = rsp_ff.send_length;
   assign rsp_reply_first = rsp_ff.reply_first;
   assign rsp_reply_second = 8'h00;
   assign rsp_address_update = rsp_ff.address_update;
   assign rsp_new_address = rsp_ff.new_address;

endmodule

@@ hw/rtl/usrd_checker.sv @@
`timescale 1ns / 1ps
// port level checks of the request decoder, bound to the top level
module usrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_opcode,
   input logic [7:0]  req_request_type,
   input logic [7:0]  req_request_code,
   input logic        rsp_valid,
   input logic [1:0]  rsp_action,
   input logic        rsp_from_descriptor,
   input logic [15:0] rsp_send_length,
   input logic        rsp_address_update
);

   logic accept;
   logic desc_req;

   assign accept = start && !busy;
   assign desc_req = ({req_request_code, req_request_type} == usrd_pkg::REQ_GET_DESC_DEV) ||
                     ({req_request_code, req_request_type} == usrd_pkg::REQ_GET_DESC_IF);

   // a table write answers in the next cycle
   a_write_answer: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == usrd_pkg::OP_WRITE_SLOT |=>
         rsp_valid && rsp_action == usrd_pkg::ACT_WRITTEN)
      else $error("table write transaction not answered");

   // requests without a table lookup answer in the next cycle
   a_plain_answer: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == usrd_pkg::OP_SETUP && !desc_req |=> rsp_valid)
      else $error("setup transaction not answered");

   a_no_data_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != usrd_pkg::ACT_SEND |->
         rsp_send_length == 16'd0 && !rsp_from_descriptor)
      else $error("length or descriptor flag on a non-data result");

   a_addr_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_address_update |-> rsp_action == usrd_pkg::ACT_ACK)
      else $error("address update without ack");

endmodule

bind usb_standard_request_decoder_unit usrd_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_opcode          (req_opcode),
   .req_request_type    (req_request_type),
   .req_request_code    (req_request_code),
   .rsp_valid           (rsp_valid),
   .rsp_action          (rsp_action),
   .rsp_from_descriptor (rsp_from_descriptor),
   .rsp_send_length     (rsp_send_length),
   .rsp_address_update  (rsp_address_update)
);
